// ----- sv/apa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apa_pkg: shared types and constants for the point-to-angle pipeline
// Binary-angle constants, polynomial coefficients and stage counts.
// ----------------------------------------------------------------------------
package apa_pkg;

	localparam int ANG_W = 32;          // binary angle, full turn = 2^32
	localparam int K1_W  = 30;
	localparam int K3_W  = 27;

	// 0.9817 and 0.1963 rad scaled by 2^31/pi
	localparam logic [K1_W-1:0] BAM_K1 = 30'd671056031;
	localparam logic [K3_W-1:0] BAM_K3 = 27'd134183864;

	// base angles and their negations (mod 2^32)
	localparam logic [ANG_W-1:0] BASE_LO     = 32'h2000_0000;
	localparam logic [ANG_W-1:0] BASE_HI     = 32'h6000_0000;
	localparam logic [ANG_W-1:0] BASE_LO_NEG = 32'hE000_0000;
	localparam logic [ANG_W-1:0] BASE_HI_NEG = 32'hA000_0000;

	localparam int FRONT_STAGES = 3;
	localparam int POLY_STAGES  = 5;

	typedef struct packed {
		logic dx_neg;   // target left of origin: base 3/8 turn
		logic dy_neg;   // final negation
		logic r_neg;    // sign of the ratio
	} apa_flags_t;

endpackage

// ----- sv/apa_pt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apa_pt_if: point-pair stream
// valid/ready channel carrying origin and target coordinates.
// ----------------------------------------------------------------------------
interface apa_pt_if #(
	parameter int W = 32
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] from_x;
	logic signed [W-1:0] from_y;
	logic signed [W-1:0] to_x;
	logic signed [W-1:0] to_y;

	modport source (output valid, output from_x, output from_y, output to_x, output to_y,
		input ready);
	modport sink (input valid, input from_x, input from_y, input to_x, input to_y,
		output ready);
endinterface

// ----- sv/apa_ang_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apa_ang_if: angle stream
// valid/ready channel carrying one binary angle per beat.
// ----------------------------------------------------------------------------
interface apa_ang_if import apa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ANG_W-1:0] angle;

	modport source (output valid, output angle, input ready);
	modport sink (input valid, input angle, output ready);
endinterface

// ----- sv/apa_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apa_front: deltas, magnitudes and ratio operands
// Three stages: dx/dy, |dx| and |dy|+1, then numerator magnitude and divisor.
// ----------------------------------------------------------------------------
module apa_front import apa_pkg::*; #(
	parameter int W = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [FRONT_STAGES-1:0] en,
	input  logic                    in_v,
	input  logic [W-1:0]            from_x,
	input  logic [W-1:0]            from_y,
	input  logic [W-1:0]            to_x,
	input  logic [W-1:0]            to_y,
	output logic [FRONT_STAGES-1:0] v,
	output logic [W:0]              nmag,
	output logic [W+1:0]            den,
	output apa_flags_t              flags
);

	logic         v_s1, v_s2, v_s3;
	logic [W:0]   dx_s1, dy_s1;
	logic [W:0]   adx_s2, ay_s2;
	logic         dxn_s2, dyn_s2;
	logic [W:0]   nmag_s3;
	logic [W+1:0] den_s3;
	apa_flags_t   flags_s3;

	logic [W:0]   dx_c, dy_c, adx_c, ay_c;
	logic [W+1:0] diff_c;
	logic         ay_lt, adx_lt;

	assign dx_c = {to_x[W-1], to_x} - {from_x[W-1], from_x};
	assign dy_c = {to_y[W-1], to_y} - {from_y[W-1], from_y};

	// |dy| + 1 in one add: -dy + 1 == ~dy + 2
	assign adx_c = dx_s1[W] ? (~dx_s1 + (W+1)'(1)) : dx_s1;
	assign ay_c  = dy_s1[W] ? (~dy_s1 + (W+1)'(2)) : (dy_s1 + (W+1)'(1));

	assign diff_c = {1'b0, ay_s2} - {1'b0, adx_s2};
	assign ay_lt  = diff_c[W+1];
	assign adx_lt = !ay_lt && (diff_c != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en[0]) v_s1 <= in_v;
			if (en[1]) v_s2 <= v_s1;
			if (en[2]) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
		end
		if (en[1]) begin
			adx_s2 <= adx_c;
			ay_s2  <= ay_c;
			dxn_s2 <= dx_s1[W];
			dyn_s2 <= dy_s1[W];
		end
		if (en[2]) begin
			nmag_s3         <= ay_lt ? (adx_s2 - ay_s2) : diff_c[W:0];
			den_s3          <= {1'b0, adx_s2} + {1'b0, ay_s2};
			flags_s3.dx_neg <= dxn_s2;
			flags_s3.dy_neg <= dyn_s2;
			// dx<0: num = ay-|dx|; else num = |dx|-ay
			flags_s3.r_neg  <= dxn_s2 ? ay_lt : adx_lt;
		end
	end

	assign v     = {v_s3, v_s2, v_s1};
	assign nmag  = nmag_s3;
	assign den   = den_s3;
	assign flags = flags_s3;

	a_ratio_operands: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (den_s3 != '0) && ({1'b0, nmag_s3} <= den_s3))
		else $error("ratio numerator exceeds divisor");

endmodule

// ----- sv/apa_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apa_div: pipelined restoring divider
// One quotient bit per stage; gives floor(n * 2^F / d) for n <= d.
// ----------------------------------------------------------------------------
module apa_div import apa_pkg::*; #(
	parameter int DW = 34,
	parameter int F  = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [F:0]      en,
	input  logic            in_v,
	input  logic [DW-2:0]   nmag,
	input  logic [DW-1:0]   den,
	input  apa_flags_t      in_flags,
	output logic [F:0]      v,
	output logic [F:0]      q,
	output apa_flags_t      flags
);

	localparam int ND = F + 1;
	localparam int QW = F + 1;
	localparam int RW = DW + 1;
	localparam logic [QW-1:0] Q_MAX = QW'(1) << F;

	logic [RW-1:0] rem_s   [ND];
	logic [DW-1:0] den_s   [ND];
	logic [QW-1:0] q_s     [ND];
	apa_flags_t    flags_s [ND];
	logic          v_s     [ND];

	for (genvar k = 0; k < ND; k++) begin : gen_stage
		logic [RW-1:0] rem_i, rem_d;
		logic [DW-1:0] den_i;
		logic [QW-1:0] q_i;
		apa_flags_t    flags_i;
		logic          v_i, ge;

		if (k == 0) begin : gen_head
			assign rem_i   = RW'(nmag);
			assign den_i   = den;
			assign q_i     = '0;
			assign flags_i = in_flags;
			assign v_i     = in_v;
		end else begin : gen_body
			assign rem_i   = rem_s[k-1];
			assign den_i   = den_s[k-1];
			assign q_i     = q_s[k-1];
			assign flags_i = flags_s[k-1];
			assign v_i     = v_s[k-1];
		end

		assign ge    = rem_i >= RW'(den_i);
		assign rem_d = ge ? (rem_i - RW'(den_i)) : rem_i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= v_i;
			end
		end

		// rem_d < d, so the shift never drops a set bit
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k]   <= {rem_d[RW-2:0], 1'b0};
				den_s[k]   <= den_i;
				q_s[k]     <= {q_i[QW-2:0], ge};
				flags_s[k] <= flags_i;
			end
		end

		assign v[k] = v_s[k];
	end

	assign q     = q_s[ND-1];
	assign flags = flags_s[ND-1];

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[ND-1] |-> (q_s[ND-1] <= Q_MAX))
		else $error("ratio magnitude above one");

endmodule

// ----- sv/apa_poly.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apa_poly: cubic polynomial and angle assembly
// r^2, K3*r^2, K1-K3*r^2, times r, then base and sign into a binary angle.
// ----------------------------------------------------------------------------
module apa_poly import apa_pkg::*; #(
	parameter int F = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [POLY_STAGES-1:0] en,
	input  logic                   in_v,
	input  logic [F:0]             q,
	input  apa_flags_t             in_flags,
	output logic [POLY_STAGES-1:0] v,
	output logic [ANG_W-1:0]       angle
);

	localparam int QW   = F + 1;
	localparam int SQ_W = 2 * QW + 1;
	localparam int KP_W = K3_W + QW + 1;
	localparam int MP_W = K1_W + QW + 1;
	localparam logic [SQ_W-1:0] SQ_HALF = SQ_W'(1) << (F - 1);
	localparam logic [KP_W-1:0] KP_HALF = KP_W'(1) << (F - 1);
	localparam logic [MP_W-1:0] MP_HALF = MP_W'(1) << (F - 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [QW-1:0]    q_s1, q_s2, q_s3;
	apa_flags_t       flags_s1, flags_s2, flags_s3, flags_s4;
	logic [QW-1:0]    r2_s1;
	logic [K3_W-1:0]  t_s2;
	logic [K1_W-1:0]  pm_s3;
	logic [K1_W-1:0]  m_s4;
	logic [ANG_W-1:0] angle_s5;

	logic [2*QW-1:0]      sq_p;
	logic [SQ_W-1:0]      sq_c;
	logic [K3_W+QW-1:0]   kp_p;
	logic [KP_W-1:0]      kp_c;
	logic [K1_W+QW-1:0]   mp_p;
	logic [MP_W-1:0]      mp_c;
	logic [ANG_W-1:0]     base_c, m_ext;

	// magnitudes only: r^2 >= 0, K1-K3*r^2 > 0, sign folded in at the end
	assign sq_p = (2*QW)'(q) * (2*QW)'(q);
	assign sq_c = {1'b0, sq_p} + SQ_HALF;
	assign kp_p = (K3_W+QW)'(BAM_K3) * (K3_W+QW)'(r2_s1);
	assign kp_c = {1'b0, kp_p} + KP_HALF;
	assign mp_p = (K1_W+QW)'(pm_s3) * (K1_W+QW)'(q_s3);
	assign mp_c = {1'b0, mp_p} + MP_HALF;

	always_comb begin
		case ({flags_s4.dx_neg, flags_s4.dy_neg})
			2'b00:   base_c = BASE_LO;
			2'b01:   base_c = BASE_LO_NEG;
			2'b10:   base_c = BASE_HI;
			default: base_c = BASE_HI_NEG;
		endcase
	end

	assign m_ext = ANG_W'(m_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en[0]) v_s1 <= in_v;
			if (en[1]) v_s2 <= v_s1;
			if (en[2]) v_s3 <= v_s2;
			if (en[3]) v_s4 <= v_s3;
			if (en[4]) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			q_s1     <= q;
			flags_s1 <= in_flags;
			r2_s1    <= sq_c[F+QW-1:F];
		end
		if (en[1]) begin
			q_s2     <= q_s1;
			flags_s2 <= flags_s1;
			t_s2     <= kp_c[F+K3_W-1:F];
		end
		if (en[2]) begin
			q_s3     <= q_s2;
			flags_s3 <= flags_s2;
			pm_s3    <= BAM_K1 - K1_W'(t_s2);
		end
		if (en[3]) begin
			flags_s4 <= flags_s3;
			m_s4     <= mp_c[F+K1_W-1:F];
		end
		if (en[4]) begin
			// term = r_neg ? +m : -m, and the whole sum flips with dy_neg
			angle_s5 <= (flags_s4.r_neg != flags_s4.dy_neg) ? (base_c + m_ext)
			                                                 : (base_c - m_ext);
		end
	end

	assign v     = {v_s5, v_s4, v_s3, v_s2, v_s1};
	assign angle = angle_s5;

	a_k3_term: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (t_s2 <= BAM_K3))
		else $error("cubic coefficient term out of range");

	a_poly_term: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (m_s4 <= BAM_K1))
		else $error("polynomial product out of range");

endmodule

// ----- sv/approx_point_to_angle_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// approx_point_to_angle_top: direction between two points as a binary angle
// Cubic atan2 approximation over a ratio from a pipelined divider.
// ----------------------------------------------------------------------------
//
//  channel | role   | payload                          | beat
//  --------+--------+----------------------------------+---------------------
//  pt      | sink   | from_x, from_y, to_x, to_y (Q16) | valid & ready
//  ang     | source | angle (2^32 per turn)            | valid & ready
//
// One beat per cycle sustained unless the output is held. Stages: three
// front stages, one divider stage per quotient bit (RATIO_FRAC_BITS + 1),
// five polynomial stages, the last of which is the output register.
// The divider, one restoring step per stage, sets the depth.
// Reset clears only the valid bits; there is no stored state.
// Stalls: each stage loads when any stage at or after it is empty or the
// output is taken, so bubbles collapse and pt.ready drops only with a full
// pipeline and a held output.
// ----------------------------------------------------------------------------
module approx_point_to_angle_top import apa_pkg::*; #(
	parameter int COORD_WIDTH     = 32,
	parameter int RATIO_FRAC_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	apa_pt_if.sink     pt,
	apa_ang_if.source  ang
);

	localparam int W  = COORD_WIDTH;
	localparam int F  = RATIO_FRAC_BITS;
	localparam int DW = W + 2;           // divisor |dx| + |dy| + 1
	localparam int ND = F + 1;           // divider stages
	localparam int NS = FRONT_STAGES + ND + POLY_STAGES;

	logic [NS-1:0] en;
	logic [NS-1:0] v_all;

	logic [FRONT_STAGES-1:0] v_front;
	logic [ND-1:0]           v_div;
	logic [POLY_STAGES-1:0]  v_poly;

	logic [W:0]    nmag;
	logic [DW-1:0] den;
	apa_flags_t    flags_front, flags_div;
	logic [F:0]    q;

	assign v_all = {v_poly, v_div, v_front};

	// stage k may load if the output drains or stage k or some later stage is a bubble
	always_comb begin
		for (int k = 0; k < NS; k++) begin
			en[k] = ang.ready | (|(~v_all & ({NS{1'b1}} << k)));
		end
	end

	assign pt.ready  = en[0];
	assign ang.valid = v_all[NS-1];

	apa_front #(
		.W (W)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en[FRONT_STAGES-1:0]),
		.in_v   (pt.valid),
		.from_x (pt.from_x[W-1:0]),
		.from_y (pt.from_y[W-1:0]),
		.to_x   (pt.to_x[W-1:0]),
		.to_y   (pt.to_y[W-1:0]),
		.v      (v_front),
		.nmag   (nmag),
		.den    (den),
		.flags  (flags_front)
	);

	apa_div #(
		.DW (DW),
		.F  (F)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en[FRONT_STAGES+ND-1:FRONT_STAGES]),
		.in_v     (v_front[FRONT_STAGES-1]),
		.nmag     (nmag),
		.den      (den),
		.in_flags (flags_front),
		.v        (v_div),
		.q        (q),
		.flags    (flags_div)
	);

	apa_poly #(
		.F (F)
	) u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en[NS-1:FRONT_STAGES+ND]),
		.in_v     (v_div[ND-1]),
		.q        (q),
		.in_flags (flags_div),
		.v        (v_poly),
		.angle    (ang.angle)
	);

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pt.ready |-> (&v_all) && !ang.ready)
		else $error("input stalled with a bubble in the pipeline");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(pt.valid && pt.ready) |=> v_all[0])
		else $error("accepted beat missing from first stage");

endmodule
